// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Word formats, operation and status codes, cell command and tree sizing.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_W       = 32;
   localparam int OP_W        = 2;
   localparam int STAT_W      = 2;
   localparam int POS_W       = 9;
   localparam int TREE_RADIX  = 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  match_count;
      logic [POS_W-1:0]  fill_level;
   } rsp_type;

   typedef struct packed {
      logic             compare;
      logic             insert;
      logic             remove;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

   // Node count at a given level of a TREE_RADIX-wide reduction tree.
   function automatic int tree_nodes(input int n, input int lvl);
      int c;
      c = n;
      for (int i = 0; i < lvl; i++) begin
         c = (c + TREE_RADIX - 1) / TREE_RADIX;
      end
      return c;
   endfunction

   // Register levels needed to bring n leaves down to one node.
   function automatic int tree_levels(input int n);
      int c;
      int l;
      c = n;
      l = 0;
      while (c > 1) begin
         c = (c + TREE_RADIX - 1) / TREE_RADIX;
         l++;
      end
      return l;
   endfunction

endpackage

// ----- rtl/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key chain
// Holds one key, compares it against the broadcast key and shifts toward
// either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module skt_cell
   import skt_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 9
) (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [CW-1:0]    count,
   input  logic [KEY_W-1:0] left_key,
   input  logic             left_lt,
   input  logic             left_le,
   input  logic [KEY_W-1:0] right_key,
   output logic [KEY_W-1:0] key_q,
   output logic             lt_q,
   output logic             le_q,
   output logic             lt_mark,
   output logic             le_mark
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             lt_ff, lt_in;
   logic             le_ff, le_in;
   logic             occupied;

   assign occupied = count > CW'(IDX);

   always_comb begin
      lt_in  = lt_ff;
      le_in  = le_ff;
      key_in = key_ff;
      if (cmd.compare) begin
         lt_in = occupied && (key_ff < cmd.key);
         le_in = occupied && (key_ff <= cmd.key);
      end
      // entries at or above the boundary move; on insert the boundary slot takes the key
      priority if (cmd.insert) begin
         if (!lt_ff) begin
            key_in = left_lt ? cmd.key : left_key;
         end
      end else if (cmd.remove) begin
         if (!lt_ff) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      le_ff  <= le_in;
   end

   assign key_q   = key_ff;
   assign lt_q    = lt_ff;
   assign le_q    = le_ff;
   assign lt_mark = !lt_ff && left_lt;
   assign le_mark = !le_ff && left_le;

endmodule

// ----- rtl/skt_or_tree.sv -----
// ----------------------------------------------------------------------------
// skt_or_tree: registered OR reduction tree
// Folds N leaf words into one word by bitwise OR, one register per level.
// ----------------------------------------------------------------------------
module skt_or_tree
   import skt_pkg::*;
#(
   parameter int N = 257,
   parameter int W = 18
) (
   input  logic           clock,
   input  logic [N*W-1:0] leaf,
   output logic [W-1:0]   root
);

   localparam int LEVELS = tree_levels(N);

   logic [W-1:0] node [LEVELS+1][N];

   for (genvar i = 0; i < N; i++) begin : g_leaf
      assign node[0][i] = leaf[i*W +: W];
   end

   for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
      localparam int PREV = tree_nodes(N, l - 1);
      localparam int CUR  = tree_nodes(N, l);
      for (genvar j = 0; j < CUR; j++) begin : g_node
         logic [W-1:0] or_in;
         always_comb begin
            or_in = '0;
            for (int k = 0; k < TREE_RADIX; k++) begin
               if (j * TREE_RADIX + k < PREV) begin
                  or_in = or_in | node[l-1][j * TREE_RADIX + k];
               end
            end
         end
         always_ff @(posedge clock) begin
            node[l][j] <= or_in;
         end
      end
   end

   assign root = node[LEVELS][0];

endmodule

// ----- rtl/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table: ascending key table with insert, delete and search
// A chain of key cells kept in sorted order, with a registered tree that
// turns the compare boundary into positions and match counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one request word: op and key.
//   rsp_valid/rsp_ready/rsp_data carry one response word per request:
//   status, position, match_count and fill_level after the operation.
//   Every cell compares its key with the request key in the accept cycle.
//   The boundary marks then fold through a registered OR tree of
//   tree_levels(DEPTH+1) stages (3 for 256 entries, 5 for 4096), and in the
//   finish cycle the cells shift up or down by one when an insert or delete
//   succeeds, and the response word is loaded. One request is in flight at a
//   time: the next is accepted only once the last has left its finish cycle.
//   The response register is a separate stage: a new request is accepted
//   while the last response still waits. If the receiver stalls, the next
//   operation holds in its finish cycle until the response slot frees.
//   Reset empties the table (fill count zero); no clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int LEAVES = DEPTH + 1;
   localparam int LEVELS = tree_levels(LEAVES);
   localparam int LVL_W  = $clog2(LEVELS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_REDUCE,
      S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] lvl_cnt_ff, lvl_cnt_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_cmd_type     cmd;
   logic [KEY_W-1:0] cell_key [DEPTH];
   logic [DEPTH-1:0] cell_lt;
   logic [DEPTH-1:0] cell_le;
   logic [DEPTH:0]   lt_mark;
   logic [DEPTH:0]   le_mark;
   logic [LEAVES*2*CW-1:0] leaf;
   logic [2*CW-1:0]  root;
   logic [CW-1:0]    pos_lt;
   logic [CW-1:0]    pos_le;
   logic             found;
   logic             full;
   logic             accept;
   logic             slot_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ---- cell chain ---------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] left_key;
      logic             left_lt;
      logic             left_le;
      logic [KEY_W-1:0] right_key;

      if (i == 0) begin : g_head
         // head of chain: nothing below it, so it sits right of the boundary
         assign left_key = cmd.key;
         assign left_lt  = 1'b1;
         assign left_le  = 1'b1;
      end else begin : g_body
         assign left_key = cell_key[i-1];
         assign left_lt  = cell_lt[i-1];
         assign left_le  = cell_le[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_key = cell_key[i];
      end else begin : g_mid
         assign right_key = cell_key[i+1];
      end

      skt_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .left_key  (left_key),
         .left_lt   (left_lt),
         .left_le   (left_le),
         .right_key (right_key),
         .key_q     (cell_key[i]),
         .lt_q      (cell_lt[i]),
         .le_q      (cell_le[i]),
         .lt_mark   (lt_mark[i]),
         .le_mark   (le_mark[i])
      );
   end

   // boundary past the last cell: every slot lies below the key
   assign lt_mark[DEPTH] = cell_lt[DEPTH-1];
   assign le_mark[DEPTH] = cell_le[DEPTH-1];

   // ---- boundary encoding --------------------------------------------------
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      assign leaf[i*2*CW +: 2*CW] = {(le_mark[i] ? CW'(i) : CW'(0)),
                                     (lt_mark[i] ? CW'(i) : CW'(0))};
   end

   skt_or_tree #(
      .N (LEAVES),
      .W (2 * CW)
   ) u_tree (
      .clock (clock),
      .leaf  (leaf),
      .root  (root)
   );

   assign pos_lt = root[CW-1:0];
   assign pos_le = root[2*CW-1:CW];
   assign found  = pos_le != pos_lt;
   assign full   = count_ff == CW'(DEPTH);

   // ---- sequencing ---------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      lvl_cnt_in   = lvl_cnt_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      cmd.compare = accept;
      cmd.insert  = 1'b0;
      cmd.remove  = 1'b0;
      cmd.key     = (state_ff == S_IDLE) ? req_data.key : key_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_data.op;
               key_in     = req_data.key;
               lvl_cnt_in = LVL_W'(LEVELS - 1);
               state_in   = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (lvl_cnt_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               lvl_cnt_in = lvl_cnt_ff - 1'b1;
            end
         end
         S_FINISH: begin
            // hold until the response slot frees, then update and report
            if (slot_free) begin
               rsp_in.status      = STAT_OK;
               rsp_in.position    = '0;
               rsp_in.match_count = '0;
               unique case (op_ff)
                  OP_INSERT: begin
                     if (full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        cmd.insert      = 1'b1;
                        count_in        = count_ff + 1'b1;
                        rsp_in.position = POS_W'(pos_lt);
                     end
                  end
                  OP_DELETE: begin
                     if (found) begin
                        cmd.remove      = 1'b1;
                        count_in        = count_ff - 1'b1;
                        rsp_in.position = POS_W'(pos_lt);
                     end else begin
                        rsp_in.status = STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                     // search, and the unused code that behaves as one
                     if (found) begin
                        rsp_in.position    = POS_W'(pos_lt);
                        rsp_in.match_count = POS_W'(pos_le - pos_lt);
                     end else begin
                        rsp_in.status = STAT_NOT_FOUND;
                     end
                  end
               endcase
               rsp_in.fill_level = POS_W'(count_in);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_cnt_ff   <= lvl_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
